[sv/vam_pkg.sv]
package vam_pkg;
    typedef enum logic [2:0] {
        MODE_PLAY   = 3'd0,
        MODE_STOP   = 3'd1,
        MODE_RENDER = 3'd2,
        MODE_LOAD   = 3'd3,
        MODE_ENABLE = 3'd4
    } mode_t;

    // voice pool size; slot and count fields below are sized for it
    localparam int VOICES   = 8;

    localparam int MODE_W   = 3;
    localparam int EFFECT_W = 4;
    localparam int ADDR_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 4;
    localparam int MIX_W    = 22;
    localparam logic signed [MIX_W-1:0] SAT_HI = 22'sd32767;
    localparam logic signed [MIX_W-1:0] SAT_LO = -22'sd32768;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [EFFECT_W-1:0] effect;
        logic                looping;
        logic [ADDR_W-1:0]   sample_addr;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                is_last_word;
        logic                enable_flag;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [SLOT_W-1:0]   granted_slot;
        logic [COUNT_W-1:0]  active_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch request, run the non-render ops
        logic visit;    // render: process voice at visit index
        logic clear;    // render: clear mix accumulator
        logic finish;   // form response
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic render;
        logic last_voice;
    } sts_t;
endpackage

[sv/vam_if.sv]
interface vam_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/vam_ctrl.sv]
module vam_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output vam_pkg::cmd_t cmd,
    input  vam_pkg::sts_t sts
);
    import vam_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_FETCH, S_ACC, S_DONE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.render)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                // sample read address set up; word arrives next cycle
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.visit  = 1'b1;
                state_next = sts.last_voice ? S_DONE : S_FETCH;
            end
            S_DONE:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[sv/vam_dp.sv]
module vam_dp #(
    parameter int EFFECTS      = 16,
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  vam_pkg::req_t req,
    input  vam_pkg::cmd_t cmd,
    output vam_pkg::sts_t sts,
    output vam_pkg::rsp_t rsp
);
    import vam_pkg::*;

    localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int EI_W  = (EFFECTS > 1) ? $clog2(EFFECTS) : 1;
    localparam int SD_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int LEN_W = SD_W + 1;
    localparam int MEM_DEPTH = EFFECTS * (2 ** SD_W);
    localparam int MA_W  = EI_W + SD_W;

    logic [EI_W-1:0]  v_eff_reg [VOICES];
    logic [LEN_W-1:0] v_off_reg [VOICES];
    logic [VOICES-1:0] v_act_reg, v_loop_reg;
    logic [SLOT_W-1:0] amb_reg;
    logic [VI_W-1:0]   steal_reg;
    logic              en_reg;
    logic [LEN_W-1:0]  len_reg [EFFECTS];
    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_reg;

    req_t              r_reg;
    logic [VI_W-1:0]   vi_reg;
    logic signed [MIX_W-1:0] mix_reg;
    logic [SLOT_W-1:0] grant_reg;
    rsp_t              rsp_reg;

    // play decision (narrow priority search over the voices)
    logic [SLOT_W-1:0] free_slot, steal_slot, play_slot;
    logic              eff_ok;
    always_comb
    begin
        free_slot  = SLOT_W'(VOICES);
        steal_slot = SLOT_W'(VOICES);
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!v_act_reg[i]) free_slot = SLOT_W'(i);
        end
        for (int p = VOICES - 1; p >= 0; p--)
        begin
            if (!v_loop_reg[(32'(steal_reg) + p) % VOICES])
                steal_slot = SLOT_W'((32'(steal_reg) + p) % VOICES);
        end
        eff_ok    = 32'(req.effect) < EFFECTS;
        play_slot = SLOT_W'(VOICES);
        if (eff_ok && !(req.looping && amb_reg < SLOT_W'(VOICES)))
        begin
            if (free_slot != SLOT_W'(VOICES)) play_slot = free_slot;
            else if (!req.looping) play_slot = steal_slot;
        end
    end

    // render visit of voice vi_reg
    logic [EI_W-1:0]  cur_eff;
    logic [LEN_W-1:0] cur_len, cur_off, use_off;
    logic             cur_play;
    always_comb
    begin
        cur_eff  = v_eff_reg[vi_reg];
        cur_len  = len_reg[cur_eff];
        cur_off  = v_off_reg[vi_reg];
        use_off  = cur_off;
        cur_play = v_act_reg[vi_reg];
        if (cur_off >= cur_len)
        begin
            if (v_loop_reg[vi_reg] && cur_len != '0) use_off = '0;
            else cur_play = 1'b0;
        end
    end

    logic [MA_W-1:0] rd_addr;
    assign rd_addr = {cur_eff, use_off[SD_W-1:0]};

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (cmd.start && req.mode == MODE_LOAD && eff_ok
            && 32'(req.sample_addr) < SAMPLE_DEPTH)
        begin
            mem[{EI_W'(req.effect), SD_W'(req.sample_addr)}] <= req.sample_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_reg <= req;
        end
    end

    logic signed [MIX_W-1:0] sat;
    always_comb
    begin
        sat = mix_reg;
        if (mix_reg > SAT_HI) sat = SAT_HI;
        if (mix_reg < SAT_LO) sat = SAT_LO;
    end

    assign sts.render     = (r_reg.mode == MODE_RENDER) && en_reg;
    assign sts.last_voice = (32'(vi_reg) == VOICES - 1);
    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                v_eff_reg[i] <= '0;
                v_off_reg[i] <= '0;
            end
            for (int e = 0; e < EFFECTS; e++) len_reg[e] <= '0;
            v_act_reg  <= '0;
            v_loop_reg <= '0;
            amb_reg    <= SLOT_W'(VOICES);
            steal_reg  <= '0;
            en_reg     <= 1'b1;
            vi_reg     <= '0;
            mix_reg    <= '0;
            grant_reg  <= SLOT_W'(VOICES);
            rsp_reg    <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                grant_reg <= (req.mode == MODE_PLAY) ? play_slot : SLOT_W'(VOICES);
                case (req.mode)
                    MODE_PLAY:
                    begin
                        if (play_slot != SLOT_W'(VOICES))
                        begin
                            v_eff_reg[play_slot[VI_W-1:0]]  <= EI_W'(req.effect);
                            v_off_reg[play_slot[VI_W-1:0]]  <= '0;
                            v_act_reg[play_slot[VI_W-1:0]]  <= 1'b1;
                            v_loop_reg[play_slot[VI_W-1:0]] <= req.looping;
                            if (req.looping) amb_reg <= play_slot;
                            if (free_slot == SLOT_W'(VOICES))
                                steal_reg <= VI_W'((32'(play_slot) + 1) % VOICES);
                        end
                    end
                    MODE_STOP:
                    begin
                        if (amb_reg < SLOT_W'(VOICES))
                        begin
                            v_act_reg[amb_reg[VI_W-1:0]]  <= 1'b0;
                            v_loop_reg[amb_reg[VI_W-1:0]] <= 1'b0;
                        end
                        amb_reg <= SLOT_W'(VOICES);
                    end
                    MODE_LOAD:
                    begin
                        if (eff_ok && 32'(req.sample_addr) < SAMPLE_DEPTH && req.is_last_word)
                            len_reg[EI_W'(req.effect)] <= LEN_W'(req.sample_addr) + 1'b1;
                    end
                    MODE_ENABLE:
                    begin
                        if (req.enable_flag != en_reg)
                        begin
                            en_reg <= req.enable_flag;
                            if (!req.enable_flag)
                            begin
                                v_act_reg  <= '0;
                                v_loop_reg <= '0;
                                amb_reg    <= SLOT_W'(VOICES);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.clear)
            begin
                mix_reg <= '0;
                vi_reg  <= '0;
            end
            if (cmd.visit)
            begin
                if (v_act_reg[vi_reg])
                begin
                    if (cur_play)
                    begin
                        mix_reg <= mix_reg + MIX_W'(rd_reg);
                        v_off_reg[vi_reg] <= use_off + 1'b1;
                    end
                    else
                    begin
                        v_act_reg[vi_reg] <= 1'b0;
                    end
                end
                vi_reg <= vi_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_reg.mixed_sample <= sts.render ? SAMPLE_W'(sat) : '0;
                rsp_reg.granted_slot <= grant_reg;
                rsp_reg.active_count <= COUNT_W'($countones(v_act_reg));
            end
        end
    end
endmodule

[sv/voice_allocator_and_mixer_unit.sv]
// channel | dir | payload
// req     | in  | mode, effect, looping, sample_addr, sample_value, is_last_word, enable_flag
// rsp     | out | mixed_sample, granted_slot, active_count
// One request at a time. Render, when enabled, visits each voice in turn with one
// sample-store read and one accumulate; other modes skip the voice visits.
// Reset clears voices, lengths and state; the sample store is not cleared.
// A response waits in its register until taken; the next request can be taken
// in the same cycle the response leaves.
module voice_allocator_and_mixer_unit #(
    parameter int EFFECTS      = 16,
    parameter int SAMPLE_DEPTH = 4096
) (
    input logic clk,
    input logic rst_n,
    vam_if.sink   req,
    vam_if.source rsp
);
    import vam_pkg::*;

    cmd_t cmd;
    sts_t sts;
    rsp_t rsp_data;

    vam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vam_dp #(
        .EFFECTS      (EFFECTS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp_data)
    );

    assign rsp.data = rsp_data;
endmodule

[test/vam_checker.sv]
module vam_checker
    import vam_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vam_if       req,
    vam_if       rsp,
    output int   errors,
    output int   pending
);
    localparam int NV    = 8;
    localparam int NE    = 16;
    localparam int DEPTH = 4096;

    logic [EFFECT_W-1:0]        v_eff  [NV];
    logic [12:0]                v_off  [NV];
    logic                       v_act  [NV];
    logic                       v_loop [NV];
    int                         amb_slot;
    logic [2:0]                 steal_ptr;
    logic                       enabled;
    logic [12:0]                eff_len [NE];
    logic signed [SAMPLE_W-1:0] pcm [NE*DEPTH];
    rsp_t                       expected_q [$];

    function automatic void drop_ambient();
        if (amb_slot < NV) begin
            v_act[amb_slot]  = 1'b0;
            v_loop[amb_slot] = 1'b0;
        end
        amb_slot = NV;
    endfunction

    function automatic rsp_t mix_and_allocate(req_t r);
        rsp_t o;
        int   slot;
        int   c;
        int   acc;
        int   n;
        int   e;
        o.mixed_sample = '0;
        o.granted_slot = SLOT_W'(NV);
        case (r.mode)
            MODE_PLAY: begin
                slot = NV;
                if (!(r.looping && amb_slot < NV)) begin
                    for (int i = 0; i < NV; i++)
                        if (!v_act[i] && slot == NV) slot = i;
                    if (slot == NV && !r.looping) begin
                        for (int p = 0; p < NV; p++) begin
                            c = (int'(steal_ptr) + p) % NV;
                            if (!v_loop[c] && slot == NV) slot = c;
                        end
                        if (slot != NV) steal_ptr = 3'((slot + 1) % NV);
                    end
                    if (slot != NV) begin
                        v_eff[slot]  = r.effect;
                        v_off[slot]  = '0;
                        v_act[slot]  = 1'b1;
                        v_loop[slot] = r.looping;
                        if (r.looping) amb_slot = slot;
                    end
                end
                o.granted_slot = SLOT_W'(slot);
            end
            MODE_STOP: drop_ambient();
            MODE_RENDER: begin
                acc = 0;
                if (enabled) begin
                    for (int i = 0; i < NV; i++) begin
                        if (v_act[i]) begin
                            e = v_eff[i];
                            if (v_off[i] >= eff_len[e]) begin
                                if (v_loop[i] && eff_len[e] != 0) v_off[i] = '0;
                                else v_act[i] = 1'b0;
                            end
                            if (v_act[i]) begin
                                acc += int'(pcm[e*DEPTH + v_off[i]]);
                                v_off[i]++;
                            end
                        end
                    end
                end
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                o.mixed_sample = SAMPLE_W'(acc);
            end
            MODE_LOAD: begin
                pcm[r.effect*DEPTH + r.sample_addr] = r.sample_value;
                if (r.is_last_word) eff_len[r.effect] = 13'(r.sample_addr) + 13'd1;
            end
            MODE_ENABLE: begin
                if (r.enable_flag != enabled) begin
                    enabled = r.enable_flag;
                    if (!r.enable_flag) begin
                        drop_ambient();
                        for (int i = 0; i < NV; i++) begin
                            v_act[i]  = 1'b0;
                            v_loop[i] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < NV; i++)
            if (v_act[i]) n++;
        o.active_count = COUNT_W'(n);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t exp_r;
        rsp_t got;
        int   bad;
        bad = 0;
        if (!rst_n) begin
            for (int i = 0; i < NV; i++) begin
                v_eff[i]  = '0;
                v_off[i]  = '0;
                v_act[i]  = 1'b0;
                v_loop[i] = 1'b0;
            end
            for (int i = 0; i < NE; i++) eff_len[i] = '0;
            amb_slot  = NV;
            steal_ptr = '0;
            enabled   = 1'b1;
            expected_q.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            // response first: a request taken this edge cannot be answered yet
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                if (expected_q.size() == 0) begin
                    $error("response with no request outstanding");
                    bad++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.mixed_sample !== exp_r.mixed_sample) begin
                        $error("mixed_sample: expected %0d, actual %0d",
                               exp_r.mixed_sample, got.mixed_sample);
                        bad++;
                    end
                    if (got.granted_slot !== exp_r.granted_slot) begin
                        $error("granted_slot: expected %0d, actual %0d",
                               exp_r.granted_slot, got.granted_slot);
                        bad++;
                    end
                    if (got.active_count !== exp_r.active_count) begin
                        $error("active_count: expected %0d, actual %0d",
                               exp_r.active_count, got.active_count);
                        bad++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.insert(expected_q.size(), mix_and_allocate(req.data));
            errors  <= errors + bad;
            pending <= expected_q.size();
        end
    end
endmodule

[test/voice_allocator_and_mixer_unit_test.sv]
module voice_allocator_and_mixer_unit_test;
    import vam_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   burst_left;
    int   stall_kind;
    int   stall_left;
    int   prefix [16];

    vam_if #(.T(req_t)) req_ch ();
    vam_if #(.T(rsp_t)) rsp_ch ();

    voice_allocator_and_mixer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    vam_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_kind = 0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 150);
            end
            stall_left--;
            case (stall_kind)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic issue(input req_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    function automatic req_t make_req(logic [MODE_W-1:0] m, int eff, logic loop,
                                      int addr, int val, logic last, logic en);
        req_t r;
        r.mode         = m;
        r.effect       = EFFECT_W'(eff);
        r.looping      = loop;
        r.sample_addr  = ADDR_W'(addr);
        r.sample_value = SAMPLE_W'(val);
        r.is_last_word = last;
        r.enable_flag  = en;
        return r;
    endfunction

    // tracked so that a render never reaches a word that was never loaded
    task automatic load_word(int eff, int addr, int val, logic last);
        issue(make_req(MODE_LOAD, eff, 1'b0, addr, val, last, 1'b0));
        if (addr == prefix[eff]) prefix[eff]++;
    endtask

    initial
    begin
        req_t r;
        int   k;
        int   e;
        int   a;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        burst_left   = 0;
        for (int i = 0; i < 16; i++) prefix[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturating samples, steal, disable, ambient corner cases
        for (int i = 0; i < 3; i++) load_word(0, i, 32767, i == 2);
        load_word(15, 0, -32768, 1'b0);
        load_word(15, 1, -32768, 1'b1);
        load_word(1, 4095, 'h1234, 1'b0);
        for (int i = 0; i < 9; i++)
            issue(make_req(MODE_PLAY, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_PLAY, 0, 1'b1, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_RENDER, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_ENABLE, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_ENABLE, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_PLAY, 15, 1'b1, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_PLAY, 15, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_RENDER, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_ENABLE, 0, 1'b0, 0, 0, 1'b0, 1'b1));
        issue(make_req(MODE_ENABLE, 0, 1'b0, 0, 0, 1'b0, 1'b1));
        issue(make_req(MODE_PLAY, 15, 1'b1, 0, 0, 1'b0, 1'b0));
        for (int i = 0; i < 4; i++)
            issue(make_req(MODE_RENDER, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_STOP, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        // looping voice on an empty effect retires but keeps the ambient claim
        issue(make_req(MODE_PLAY, 2, 1'b1, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_RENDER, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_PLAY, 15, 1'b1, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_STOP, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_W'(MODE_ENABLE + 1), 0, 1'b0, 0, 0, 1'b0, 1'b0));
        issue(make_req(MODE_W'(MODE_ENABLE + 3), 0, 1'b0, 0, 0, 1'b0, 1'b0));

        for (int n = 0; n < 600; n++) begin
            r = req_t'({$urandom, $urandom});
            k = $urandom_range(0, 99);
            if (k < 30) begin
                r.mode    = MODE_PLAY;
                r.looping = ($urandom_range(0, 4) == 0);
                issue(r);
            end else if (k < 65) begin
                r.mode = MODE_RENDER;
                issue(r);
            end else if (k < 82) begin
                e = $urandom_range(0, 15);
                if (prefix[e] < 12 && $urandom_range(0, 1) != 0) a = prefix[e];
                else if (prefix[e] > 0 && $urandom_range(0, 2) != 0)
                    a = $urandom_range(0, prefix[e] - 1);
                else a = $urandom_range(0, 4095);
                case ($urandom_range(0, 3))
                    0:       k = 32767;
                    1:       k = -32768;
                    default: k = int'($signed(16'($urandom)));
                endcase
                load_word(e, a, k, a < prefix[e] && $urandom_range(0, 2) == 0);
            end else if (k < 90) begin
                r.mode = MODE_STOP;
                issue(r);
            end else if (k < 97) begin
                r.mode        = MODE_ENABLE;
                r.enable_flag = ($urandom_range(0, 3) != 0);
                issue(r);
            end else begin
                r.mode = MODE_W'($urandom_range(MODE_ENABLE + 1, 7));
                issue(r);
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
sv/vam_pkg.sv
sv/vam_if.sv
sv/vam_ctrl.sv
sv/vam_dp.sv
sv/voice_allocator_and_mixer_unit.sv
test/vam_checker.sv
test/voice_allocator_and_mixer_unit_test.sv
